/* sv/flpw_pkg.sv */
// ----------------------------------------------------------------------------
// flpw_pkg
// Shared types, constants and helper functions of the four-level page walker.
// ----------------------------------------------------------------------------
package flpw_pkg;

    // Entry store depth; a power of two so the slot wrap is a bit-select
    localparam int STORE_WORDS = 4096;
    localparam int IDX_W       = $clog2(STORE_WORDS);

    localparam int ENTRY_W = 64;
    localparam int LIN_W   = 48;
    localparam int PA_W    = 52;
    localparam int FRAME_W = 40;
    localparam int TIDX_W  = 9;
    localparam int WIDX_W  = 12;
    localparam int SLOT_EXT_W = FRAME_W + TIDX_W;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_RW      = 1;
    localparam int BIT_PS      = 7;
    localparam int BIT_XD      = 63;

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_CHECK     = 2'd1,
        OP_APPLY     = 2'd2,
        OP_LOAD      = 2'd3
    } flpw_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_LOAD,
        ST_FIN
    } flpw_state_t;

    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDPT = 2'd1,
        LVL_PD   = 2'd2,
        LVL_PT   = 2'd3
    } flpw_level_t;

    typedef struct packed {
        logic                 rd;
        logic                 wr;
        logic [IDX_W-1:0]     addr;
        logic [ENTRY_W-1:0]   wdata;
    } flpw_mem_req_t;

    // Store word of entry idx in the table at frame, wrapped to the store size
    function automatic logic [IDX_W-1:0] slot_of(input logic [FRAME_W-1:0] frame,
                                                 input logic [TIDX_W-1:0] idx);
        logic [SLOT_EXT_W-1:0] full;
        full = {frame, idx};
        return full[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] word_slot(input logic [WIDX_W-1:0] widx);
        logic [SLOT_EXT_W-1:0] full;
        full = SLOT_EXT_W'(widx);
        return full[IDX_W-1:0];
    endfunction

    function automatic logic [TIDX_W-1:0] level_index(input logic [LIN_W-1:0] lin,
                                                      input flpw_level_t lvl);
        logic [TIDX_W-1:0] r;
        case (lvl)
            LVL_PML4: r = lin[47:39];
            LVL_PDPT: r = lin[38:30];
            LVL_PD:   r = lin[29:21];
            LVL_PT:   r = lin[20:12];
            default:  r = lin[20:12];
        endcase
        return r;
    endfunction

    function automatic logic [FRAME_W-1:0] next_frame(input logic [ENTRY_W-1:0] e);
        return e[51:12];
    endfunction

    // Intermediate entry: add rights, never remove
    function automatic logic [ENTRY_W-1:0] grant(input logic [ENTRY_W-1:0] e,
                                                 input logic w, input logic x);
        logic [ENTRY_W-1:0] r;
        r = e;
        if (w)
        begin
            r[BIT_RW] = 1'b1;
        end
        if (x)
        begin
            r[BIT_XD] = 1'b0;
        end
        return r;
    endfunction

    // Leaf entry: set rights exactly
    function automatic logic [ENTRY_W-1:0] set_leaf(input logic [ENTRY_W-1:0] e,
                                                    input logic w, input logic x);
        logic [ENTRY_W-1:0] r;
        r = e;
        r[BIT_RW] = w;
        r[BIT_XD] = ~x;
        return r;
    endfunction

endpackage

/* sv/flpw_store.sv */
// ----------------------------------------------------------------------------
// flpw_store
// Single-port entry store with registered read data and a zeroing sweep
// after reset, one word per cycle.
// ----------------------------------------------------------------------------
module flpw_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  flpw_pkg::flpw_mem_req_t            req,
    output logic [flpw_pkg::ENTRY_W-1:0]       rdata,
    output logic                               busy
);

    logic [flpw_pkg::ENTRY_W-1:0] mem [flpw_pkg::STORE_WORDS];
    logic [flpw_pkg::ENTRY_W-1:0] rdata_reg;

    logic                         clr_busy_reg;
    logic                         clr_busy_next;
    logic [flpw_pkg::IDX_W-1:0]   clr_addr_reg;
    logic [flpw_pkg::IDX_W-1:0]   clr_addr_next;

    logic                         wr_en;
    logic [flpw_pkg::IDX_W-1:0]   wr_addr;
    logic [flpw_pkg::ENTRY_W-1:0] wr_data;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == flpw_pkg::IDX_W'(flpw_pkg::STORE_WORDS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // The sweep owns the write port until it finishes
    always_comb
    begin
        wr_en   = clr_busy_reg ? 1'b1 : req.wr;
        wr_addr = clr_busy_reg ? clr_addr_reg : req.addr;
        wr_data = clr_busy_reg ? '0 : req.wdata;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

/* sv/four_level_page_walker.sv */
// ----------------------------------------------------------------------------
// four_level_page_walker
// Four-level page table walk over an internal entry store: translate,
// check rights, apply rights and load store word.
// ----------------------------------------------------------------------------
// Sequence: a walk visits one to four levels, each with a store read (ST_READ)
// and an evaluate/write-back step (ST_EVAL) on the single store port, then
// ST_FIN loads the output register; a load passes ST_LOAD and then ST_FIN.
// One item at a time: the next transfer is taken only once the result has
// entered the output register and the walker is back in ST_IDLE.
// Reset: a sweep zeroes all 4096 store words, in_ready held low meanwhile.
// ----------------------------------------------------------------------------
module four_level_page_walker (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [flpw_pkg::FRAME_W-1:0]        root_table_frame,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [flpw_pkg::LIN_W-1:0]          linear_address,
    input  logic                                want_write,
    input  logic                                want_execute,
    input  logic [flpw_pkg::WIDX_W-1:0]         word_index,
    input  logic [flpw_pkg::ENTRY_W-1:0]        word_data,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ok,
    output logic [flpw_pkg::PA_W-1:0]           physical_address
);

    flpw_pkg::flpw_state_t          state_reg;
    flpw_pkg::flpw_state_t          state_next;

    logic [flpw_pkg::FRAME_W-1:0]   root_reg;

    flpw_pkg::flpw_op_t             op_reg;
    flpw_pkg::flpw_op_t             op_next;
    logic [flpw_pkg::LIN_W-1:0]     lin_reg;
    logic [flpw_pkg::LIN_W-1:0]     lin_next;
    logic                           w_reg;
    logic                           w_next;
    logic                           x_reg;
    logic                           x_next;
    logic [flpw_pkg::ENTRY_W-1:0]   wdata_reg;
    logic [flpw_pkg::ENTRY_W-1:0]   wdata_next;
    logic [flpw_pkg::IDX_W-1:0]     slot_reg;
    logic [flpw_pkg::IDX_W-1:0]     slot_next;
    flpw_pkg::flpw_level_t          level_reg;
    flpw_pkg::flpw_level_t          level_next;
    logic                           res_ok_reg;
    logic                           res_ok_next;
    logic [flpw_pkg::PA_W-1:0]      res_pa_reg;
    logic [flpw_pkg::PA_W-1:0]      res_pa_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_ok_reg;
    logic                           out_ok_next;
    logic [flpw_pkg::PA_W-1:0]      out_pa_reg;
    logic [flpw_pkg::PA_W-1:0]      out_pa_next;

    flpw_pkg::flpw_mem_req_t        mem_req;
    logic [flpw_pkg::ENTRY_W-1:0]   entry;
    logic                           store_busy;

    logic                           in_xfer;
    logic                           out_load;
    logic                           present;
    logic                           leaf;
    logic                           denied;
    logic                           walk_stop;
    logic [flpw_pkg::ENTRY_W-1:0]   entry_new;
    logic [flpw_pkg::PA_W-1:0]      leaf_pa;
    logic [flpw_pkg::IDX_W-1:0]     slot_down;

    flpw_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (entry),
        .busy  (store_busy)
    );

    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign out_load  = (state_reg == flpw_pkg::ST_FIN) && (!out_valid_reg || out_ready);

    // Decode the entry just read
    always_comb
    begin
        present = entry[flpw_pkg::BIT_PRESENT];
        leaf    = (level_reg == flpw_pkg::LVL_PT) ||
                  (((level_reg == flpw_pkg::LVL_PDPT) || (level_reg == flpw_pkg::LVL_PD)) &&
                   entry[flpw_pkg::BIT_PS]);
        denied  = (op_reg == flpw_pkg::OP_CHECK) &&
                  ((w_reg && !entry[flpw_pkg::BIT_RW]) || (x_reg && entry[flpw_pkg::BIT_XD]));
        walk_stop = !present || denied || leaf;
        entry_new = leaf ? flpw_pkg::set_leaf(entry, w_reg, x_reg)
                         : flpw_pkg::grant(entry, w_reg, x_reg);
        case (level_reg)
            flpw_pkg::LVL_PDPT: leaf_pa = {entry[51:30], lin_reg[29:0]};
            flpw_pkg::LVL_PD:   leaf_pa = {entry[51:21], lin_reg[20:0]};
            default:            leaf_pa = {entry[51:12], lin_reg[11:0]};
        endcase
        slot_down = flpw_pkg::slot_of(flpw_pkg::next_frame(entry),
                        flpw_pkg::level_index(lin_reg,
                            flpw_pkg::flpw_level_t'(level_reg + 2'd1)));
    end

    // Datapath registers
    always_comb
    begin
        op_next     = op_reg;
        lin_next    = lin_reg;
        w_next      = w_reg;
        x_next      = x_reg;
        wdata_next  = wdata_reg;
        slot_next   = slot_reg;
        level_next  = level_reg;
        res_ok_next = res_ok_reg;
        res_pa_next = res_pa_reg;

        if (in_xfer)
        begin
            op_next    = flpw_pkg::flpw_op_t'(opcode);
            lin_next   = linear_address;
            w_next     = want_write;
            x_next     = want_execute;
            wdata_next = word_data;
            level_next = flpw_pkg::LVL_PML4;
            if (flpw_pkg::flpw_op_t'(opcode) == flpw_pkg::OP_LOAD)
            begin
                slot_next = flpw_pkg::word_slot(word_index);
            end
            else
            begin
                slot_next = flpw_pkg::slot_of(root_reg, linear_address[47:39]);
            end
        end
        else if (state_reg == flpw_pkg::ST_EVAL)
        begin
            if (walk_stop)
            begin
                res_ok_next = present && !denied;
                res_pa_next = (present && !denied && op_reg == flpw_pkg::OP_TRANSLATE)
                              ? leaf_pa : '0;
            end
            else
            begin
                slot_next  = slot_down;
                level_next = flpw_pkg::flpw_level_t'(level_reg + 2'd1);
            end
        end
        else if (state_reg == flpw_pkg::ST_LOAD)
        begin
            res_ok_next = 1'b1;
            res_pa_next = '0;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_pa_next    = out_pa_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = res_ok_reg;
            out_pa_next    = res_pa_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            flpw_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (flpw_pkg::flpw_op_t'(opcode) == flpw_pkg::OP_LOAD)
                                 ? flpw_pkg::ST_LOAD : flpw_pkg::ST_READ;
                end
            end
            flpw_pkg::ST_READ: state_next = flpw_pkg::ST_EVAL;
            flpw_pkg::ST_EVAL: state_next = walk_stop ? flpw_pkg::ST_FIN : flpw_pkg::ST_READ;
            flpw_pkg::ST_LOAD: state_next = flpw_pkg::ST_FIN;
            flpw_pkg::ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = flpw_pkg::ST_IDLE;
                end
            end
            default:           state_next = flpw_pkg::ST_IDLE;
        endcase
    end

    // State outputs: handshake and store port
    always_comb
    begin
        in_ready      = 1'b0;
        mem_req.rd    = 1'b0;
        mem_req.wr    = 1'b0;
        mem_req.addr  = slot_reg;
        mem_req.wdata = wdata_reg;
        case (state_reg)
            flpw_pkg::ST_IDLE: in_ready = !store_busy;
            flpw_pkg::ST_READ: mem_req.rd = 1'b1;
            flpw_pkg::ST_EVAL:
            begin
                // Write back updated rights; the read in the following ST_READ sees them
                mem_req.wr    = (op_reg == flpw_pkg::OP_APPLY) && present;
                mem_req.wdata = entry_new;
            end
            flpw_pkg::ST_LOAD: mem_req.wr = 1'b1;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flpw_pkg::ST_IDLE;
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                root_reg <= root_table_frame;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        lin_reg    <= lin_next;
        w_reg      <= w_next;
        x_reg      <= x_next;
        wdata_reg  <= wdata_next;
        slot_reg   <= slot_next;
        level_reg  <= level_next;
        res_ok_reg <= res_ok_next;
        res_pa_reg <= res_pa_next;
        out_ok_reg <= out_ok_next;
        out_pa_reg <= out_pa_next;
    end

    assign out_valid        = out_valid_reg;
    assign ok               = out_ok_reg;
    assign physical_address = out_pa_reg;

`ifndef SYNTHESIS
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !in_ready)
        else $error("input taken while store sweep runs");

    a_walk_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && opcode != flpw_pkg::OP_LOAD) |=> (state_reg == flpw_pkg::ST_READ))
        else $error("walk did not start with a store read");

    a_fault_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ok || physical_address == '0))
        else $error("nonzero address on a failed result");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid && state_reg == flpw_pkg::ST_IDLE))
        else $error("finished result not presented");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd && mem_req.wr))
        else $error("store read and write in one cycle");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-level page walker. Directed walks over
// hand-built page tables come first, then phases under different root table
// frames that build random table paths with load items and walk them with
// translate, check and apply. A shadow store predicts every result, and a
// monitor compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [flpw_pkg::ENTRY_W-1:0] MASK_4K = 64'h000F_FFFF_FFFF_F000;
    localparam logic [flpw_pkg::ENTRY_W-1:0] MASK_2M = 64'h000F_FFFF_FFE0_0000;
    localparam logic [flpw_pkg::ENTRY_W-1:0] MASK_1G = 64'h000F_FFFF_C000_0000;
    localparam int PHASE_ITEMS = 110;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_NS = 600_000;

    typedef struct packed {
        flpw_pkg::flpw_op_t                op;
        logic [flpw_pkg::LIN_W-1:0]        lin;
        logic                              w;
        logic                              x;
        logic [flpw_pkg::WIDX_W-1:0]       widx;
        logic [flpw_pkg::ENTRY_W-1:0]      wdata;
    } walk_req_t;

    typedef struct packed {
        logic                              ok;
        logic [flpw_pkg::PA_W-1:0]         pa;
        logic [31:0]                       seq;
    } walk_resp_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [flpw_pkg::FRAME_W-1:0]       root_table_frame = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [1:0]                         opcode = '0;
    logic [flpw_pkg::LIN_W-1:0]         linear_address = '0;
    logic                               want_write = 1'b0;
    logic                               want_execute = 1'b0;
    logic [flpw_pkg::WIDX_W-1:0]        word_index = '0;
    logic [flpw_pkg::ENTRY_W-1:0]       word_data = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic                               ok;
    logic [flpw_pkg::PA_W-1:0]          physical_address;

    // Shadow copy of the block's state
    logic [flpw_pkg::ENTRY_W-1:0]       shadow_store [flpw_pkg::STORE_WORDS];
    logic [flpw_pkg::FRAME_W-1:0]       shadow_root = '0;

    walk_req_t            pending_reqs [$];
    walk_resp_t           expected_resps [$];
    walk_req_t            held_req;
    walk_resp_t           want_resp;
    walk_resp_t           seen_resp;
    logic                 pred_ok;
    logic [flpw_pkg::PA_W-1:0] pred_pa;
    int unsigned          pushed_count = 0;
    int unsigned          accepted_count = 0;
    int unsigned          result_count = 0;
    int unsigned          fail_count = 0;
    int unsigned          burst_left = 1;
    int unsigned          gap_left = 0;
    logic [15:0]          stall_pat = 16'hFFFF;
    int unsigned          stall_pos = 0;

    four_level_page_walker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .root_table_frame (root_table_frame),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .linear_address   (linear_address),
        .want_write       (want_write),
        .want_execute     (want_execute),
        .word_index       (word_index),
        .word_data        (word_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .ok               (ok),
        .physical_address (physical_address)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [flpw_pkg::TIDX_W-1:0] table_index(
        input logic [flpw_pkg::LIN_W-1:0] lin, input int lvl);
        return lin[(39 - 9 * lvl) +: 9];
    endfunction

    function automatic logic [flpw_pkg::WIDX_W-1:0] store_slot(
        input logic [flpw_pkg::FRAME_W-1:0] frame,
        input logic [flpw_pkg::TIDX_W-1:0] idx);
        logic [63:0] full;
        full = {15'd0, frame, idx};
        return flpw_pkg::WIDX_W'(full % 64'(flpw_pkg::STORE_WORDS));
    endfunction

    function automatic logic [flpw_pkg::ENTRY_W-1:0] make_entry(
        input logic [flpw_pkg::FRAME_W-1:0] frame,
        input logic present, input logic rw,
        input logic ps, input logic xd,
        input logic [flpw_pkg::ENTRY_W-1:0] filler);
        logic [flpw_pkg::ENTRY_W-1:0] r;
        r = filler;
        r[51:12] = frame;
        r[flpw_pkg::BIT_PRESENT] = present;
        r[flpw_pkg::BIT_RW] = rw;
        r[flpw_pkg::BIT_PS] = ps;
        r[flpw_pkg::BIT_XD] = xd;
        return r;
    endfunction

    // Walk the shadow tables for one item, updating them for apply and load
    task automatic predict_walk(input walk_req_t rq, output logic ok_o,
                                output logic [flpw_pkg::PA_W-1:0] pa_o);
        logic [flpw_pkg::FRAME_W-1:0] frame;
        logic [flpw_pkg::ENTRY_W-1:0] e;
        logic [flpw_pkg::ENTRY_W-1:0] keep;
        logic [63:0]                  lin64;
        logic [flpw_pkg::WIDX_W-1:0]  slot;
        logic                         leaf;
        logic                         done;
        int                           lvl;
        ok_o = 1'b0;
        pa_o = '0;
        frame = shadow_root;
        done = 1'b0;
        lin64 = {16'd0, rq.lin};
        if (rq.op == flpw_pkg::OP_LOAD)
        begin
            shadow_store[rq.widx % flpw_pkg::STORE_WORDS] = rq.wdata;
            ok_o = 1'b1;
        end
        else
        begin
            for (lvl = 0; lvl < 4 && !done; lvl++)
            begin
                slot = store_slot(frame, table_index(rq.lin, lvl));
                e = shadow_store[slot];
                if (!e[flpw_pkg::BIT_PRESENT])
                begin
                    done = 1'b1;
                end
                else
                begin
                    leaf = (lvl == 3) || ((lvl == 1 || lvl == 2) && e[flpw_pkg::BIT_PS]);
                    keep = !leaf ? MASK_4K : (lvl == 1) ? MASK_1G :
                           (lvl == 2) ? MASK_2M : MASK_4K;
                    if (rq.op == flpw_pkg::OP_CHECK &&
                        ((rq.w && !e[flpw_pkg::BIT_RW]) || (rq.x && e[flpw_pkg::BIT_XD])))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        if (rq.op == flpw_pkg::OP_APPLY)
                        begin
                            if (leaf)
                            begin
                                e[flpw_pkg::BIT_RW] = rq.w;
                                e[flpw_pkg::BIT_XD] = !rq.x;
                            end
                            else
                            begin
                                if (rq.w)
                                begin
                                    e[flpw_pkg::BIT_RW] = 1'b1;
                                end
                                if (rq.x)
                                begin
                                    e[flpw_pkg::BIT_XD] = 1'b0;
                                end
                            end
                            shadow_store[slot] = e;
                        end
                        if (leaf)
                        begin
                            ok_o = 1'b1;
                            done = 1'b1;
                            if (rq.op == flpw_pkg::OP_TRANSLATE)
                            begin
                                pa_o = flpw_pkg::PA_W'((e & keep) | (lin64 & ~keep));
                            end
                        end
                        else
                        begin
                            frame = e[51:12];
                        end
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned seq,
                                   input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] item %0d %s: got 0x%0h, expected 0x%0h",
                 $realtime, seq, what, got, want);
        fail_count++;
    endtask

    task automatic add_req(input flpw_pkg::flpw_op_t op,
                           input logic [flpw_pkg::LIN_W-1:0] lin,
                           input logic w, input logic x,
                           input logic [flpw_pkg::WIDX_W-1:0] widx,
                           input logic [flpw_pkg::ENTRY_W-1:0] wdata);
        walk_req_t rq;
        rq.op = op;
        rq.lin = lin;
        rq.w = w;
        rq.x = x;
        rq.widx = widx;
        rq.wdata = wdata;
        pending_reqs.push_back(rq);
        pushed_count++;
    endtask

    // Unused fields carry random values so every input bit toggles
    task automatic add_load(input logic [flpw_pkg::WIDX_W-1:0] slot,
                            input logic [flpw_pkg::ENTRY_W-1:0] data);
        add_req(flpw_pkg::OP_LOAD, flpw_pkg::LIN_W'(rand64()), 1'($urandom),
                1'($urandom), slot, data);
    endtask

    task automatic add_walk(input flpw_pkg::flpw_op_t op,
                            input logic [flpw_pkg::LIN_W-1:0] lin,
                            input logic w, input logic x);
        add_req(op, lin, w, x, flpw_pkg::WIDX_W'($urandom), rand64());
    endtask

    task automatic write_root(input logic [flpw_pkg::FRAME_W-1:0] frame);
        @(posedge clk);
        cfg_valid <= 1'b1;
        root_table_frame <= frame;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_root = frame;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (accepted_count != pushed_count || expected_resps.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed table paths followed by walks along them, some noise
    task automatic random_phase(input int n_items);
        int                           made;
        int                           lvl;
        int                           leaf_lvl;
        logic [flpw_pkg::LIN_W-1:0]   lin;
        logic [flpw_pkg::LIN_W-1:0]   low_mask;
        logic [flpw_pkg::FRAME_W-1:0] frame;
        logic [flpw_pkg::FRAME_W-1:0] nxt;
        made = 0;
        while (made < n_items)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                add_req(flpw_pkg::flpw_op_t'($urandom_range(0, 3)),
                        flpw_pkg::LIN_W'(rand64()), 1'($urandom), 1'($urandom),
                        flpw_pkg::WIDX_W'($urandom), rand64());
                made++;
            end
            else
            begin
                lin = flpw_pkg::LIN_W'(rand64());
                frame = shadow_root;
                leaf_lvl = $urandom_range(1, 3);
                for (lvl = 0; lvl <= leaf_lvl; lvl++)
                begin
                    nxt = flpw_pkg::FRAME_W'(rand64());
                    add_load(store_slot(frame, table_index(lin, lvl)),
                             make_entry(nxt, $urandom_range(0, 19) != 0,
                                        $urandom_range(0, 3) != 0,
                                        (lvl == leaf_lvl && lvl != 3) ||
                                        (lvl == 0 && $urandom_range(0, 1) == 1),
                                        $urandom_range(0, 3) == 0, rand64()));
                    frame = nxt;
                    made++;
                end
                low_mask = (leaf_lvl == 1) ? flpw_pkg::LIN_W'(48'h3FFF_FFFF) :
                           (leaf_lvl == 2) ? flpw_pkg::LIN_W'(48'h1F_FFFF) :
                                             flpw_pkg::LIN_W'(48'hFFF);
                repeat ($urandom_range(1, 4))
                begin
                    add_walk(flpw_pkg::flpw_op_t'($urandom_range(0, 2)),
                             (lin & ~low_mask) | (flpw_pkg::LIN_W'(rand64()) & low_mask),
                             1'($urandom), 1'($urandom));
                    made++;
                end
            end
        end
    endtask

    // Driver: present pending items in bursts, predict each one on its transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_walk(held_req, pred_ok, pred_pa);
                want_resp.ok = pred_ok;
                want_resp.pa = pred_pa;
                want_resp.seq = accepted_count;
                expected_resps.push_back(want_resp);
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    held_req = pending_reqs.pop_front();
                    opcode <= held_req.op;
                    linear_address <= held_req.lin;
                    want_write <= held_req.w;
                    want_execute <= held_req.x;
                    word_index <= held_req.widx;
                    word_data <= held_req.wdata;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall on a rotating pattern, check each result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_resps.size() == 0)
                begin
                    report_mismatch("result with nothing expected", result_count,
                                    64'(physical_address), 64'd0);
                end
                else
                begin
                    seen_resp = expected_resps.pop_front();
                    if (ok !== seen_resp.ok)
                    begin
                        report_mismatch("ok", seen_resp.seq, 64'(ok), 64'(seen_resp.ok));
                    end
                    if (physical_address !== seen_resp.pa)
                    begin
                        report_mismatch("physical_address", seen_resp.seq,
                                        64'(physical_address), 64'(seen_resp.pa));
                    end
                end
                result_count++;
            end
            out_ready <= stall_pat[stall_pos];
            if (stall_pos == 15)
            begin
                stall_pos = 0;
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
            end
            else
            begin
                stall_pos++;
            end
        end
    end

    initial
    begin
        int k;
        for (k = 0; k < flpw_pkg::STORE_WORDS; k++)
        begin
            shadow_store[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty store: every walk faults at the top level
        add_walk(flpw_pkg::OP_TRANSLATE, 48'h0, 1'b0, 1'b0);
        add_walk(flpw_pkg::OP_CHECK, '1, 1'b1, 1'b1);
        add_walk(flpw_pkg::OP_APPLY, 48'h0, 1'b1, 1'b1);
        add_load(12'hFFF, '1);
        add_load(12'h7FE, '0);
        // 4K path along index 511 at every level, leaf frame all ones
        add_load(12'h1FF, make_entry(40'd1, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        add_load(12'h3FF, make_entry(40'd2, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        add_load(12'h5FF, make_entry(40'd3, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        add_load(12'h7FF, make_entry('1, 1'b1, 1'b1, 1'b0, 1'b1, '0));
        add_walk(flpw_pkg::OP_TRANSLATE, '1, 1'b0, 1'b0);
        add_walk(flpw_pkg::OP_CHECK, '1, 1'b1, 1'b1);
        add_walk(flpw_pkg::OP_CHECK, '1, 1'b1, 1'b0);
        add_walk(flpw_pkg::OP_APPLY, '1, 1'b0, 1'b1);
        add_walk(flpw_pkg::OP_CHECK, '1, 1'b1, 1'b0);
        add_walk(flpw_pkg::OP_CHECK, '1, 1'b0, 1'b1);
        // 1G leaf under a read-only, no-execute top entry
        add_load(12'h000, make_entry(40'd1, 1'b1, 1'b0, 1'b0, 1'b1, '0));
        add_load(12'h200, make_entry(40'hA5_5A5A_5A5A, 1'b1, 1'b1, 1'b1, 1'b0, '0));
        add_walk(flpw_pkg::OP_TRANSLATE, 48'h0000_3FFF_FFFF, 1'b0, 1'b0);
        // 2M leaf
        add_load(12'h201, make_entry(40'd2, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        add_load(12'h400, make_entry(40'h5A_A5A5_A5A5, 1'b1, 1'b1, 1'b1, 1'b0, '0));
        add_walk(flpw_pkg::OP_TRANSLATE, 48'h0000_401F_FFFF, 1'b0, 1'b0);
        // Hole at the second level; apply still grants on the top entry
        add_walk(flpw_pkg::OP_TRANSLATE, 48'h0000_8000_0000, 1'b0, 1'b0);
        add_walk(flpw_pkg::OP_APPLY, 48'h0000_8000_1000, 1'b1, 1'b1);
        add_walk(flpw_pkg::OP_CHECK, 48'h0000_3FFF_F000, 1'b1, 1'b1);
        // Page size bit at the top level does not end the walk
        add_load(12'h005, make_entry(40'd1, 1'b1, 1'b1, 1'b1, 1'b0, '0));
        add_walk(flpw_pkg::OP_TRANSLATE, 48'h0280_1234_5678, 1'b0, 1'b0);
        wait_idle();

        write_root('1);
        random_phase(PHASE_ITEMS);
        wait_idle();
        write_root('0);
        random_phase(PHASE_ITEMS);
        wait_idle();
        write_root(flpw_pkg::FRAME_W'(rand64()));
        random_phase(PHASE_ITEMS);
        wait_idle();
        write_root(40'h80_0000_0001);
        random_phase(PHASE_ITEMS);
        wait_idle();
        write_root(flpw_pkg::FRAME_W'(rand64()));
        random_phase(PHASE_ITEMS);
        wait_idle();

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
